/* rtl/core/mpcm_pkg.sv */
package mpcm_pkg;

    localparam int CHANNELS_DEF     = 4;
    localparam int SAMPLE_DEPTH_DEF = 65536;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_PLAY      = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_STOP_ALL  = 3'd3;
    localparam logic [2:0] CMD_WRITE     = 3'd4;

    localparam logic CFG_VOLUME = 1'b0;
    localparam logic CFG_MUTE   = 1'b1;

    localparam logic [7:0] SAMPLE_MID = 8'h80;

    typedef struct packed {
        logic [2:0]        command;
        logic [7:0]        sound_id;
        logic [15:0]       start_address;
        logic [15:0]       sound_length;
        logic signed [7:0] loop_count;
        logic [15:0]       write_address;
        logic [7:0]        write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] mixed_sample;
        logic [3:0] active_channels;
    } out_item_t;

endpackage

/* rtl/core/mpcm_front.sv */
module mpcm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mpcm_pkg::in_item_t in_item,
    output logic               q_valid,
    input  logic               q_take,
    output mpcm_pkg::in_item_t q_item
);

    // Short queue; commands that do nothing are dropped here.
    mpcm_pkg::in_item_t        mem_reg [mpcm_pkg::QUEUE_DEPTH];
    logic                      wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic                      push, pop, useful;

    assign useful = (in_item.command == mpcm_pkg::CMD_TICK) ||
                    (in_item.command == mpcm_pkg::CMD_PLAY && in_item.sound_length != 16'd0) ||
                    (in_item.command == mpcm_pkg::CMD_STOP) ||
                    (in_item.command == mpcm_pkg::CMD_STOP_ALL) ||
                    (in_item.command == mpcm_pkg::CMD_WRITE);
    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall && useful;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_item   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count not advanced");

endmodule

/* rtl/core/mpcm_back.sv */
module mpcm_back
#(
    parameter int CHANNELS     = mpcm_pkg::CHANNELS_DEF,
    parameter int SAMPLE_DEPTH = mpcm_pkg::SAMPLE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_take,
    input  mpcm_pkg::in_item_t  q_item,
    input  logic [7:0]          volume,
    input  logic                mute,
    output logic                out_valid,
    input  logic                out_stall,
    output mpcm_pkg::out_item_t out_item
);

    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CW:0] CH_LAST = (CW + 1)'(CHANNELS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_PLAY  = 3'd5;

    logic [7:0] smem [SAMPLE_DEPTH];

    logic signed [7:0] plays_reg [CHANNELS];
    logic [7:0]        snd_reg   [CHANNELS];
    logic [15:0]       start_reg [CHANNELS];
    logic [15:0]       len_reg   [CHANNELS];
    logic [15:0]       ptr_reg   [CHANNELS];
    logic [15:0]       rem_reg   [CHANNELS];

    logic [2:0]          st_reg;
    logic [CW-1:0]       ch_reg;
    mpcm_pkg::in_item_t  cur_reg;
    logic [AW-1:0]       raddr;
    logic [7:0]          rdata_reg;
    logic                use_reg;
    logic signed [17:0]  prod_reg;
    logic signed [12:0]  sum_reg;
    logic                ov_reg;
    mpcm_pkg::out_item_t out_reg;
    logic signed [8:0]   sval;
    logic signed [17:0]  prod;
    logic signed [17:0]  quo;
    logic signed [12:0]  fin;
    logic [3:0]          act;
    logic [CW-1:0]       pick;
    logic                found;
    logic                act_c, wrap_c, go_c;
    logic signed [7:0]   pl_dec;

    assign q_take    = (st_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign out_item  = out_reg;

    // Per-channel decision for the channel under work.
    always_comb
    begin
        act_c  = plays_reg[ch_reg] != 8'sd0;
        wrap_c = rem_reg[ch_reg] == 16'd0;
        pl_dec = (plays_reg[ch_reg] > 8'sd0) ? plays_reg[ch_reg] - 8'sd1 : plays_reg[ch_reg];
        go_c   = act_c && (!wrap_c || pl_dec != 8'sd0);
        raddr  = AW'(wrap_c ? start_reg[ch_reg] : ptr_reg[ch_reg]);
        sval   = $signed({1'b0, rdata_reg}) - 9'sd128;
        prod   = sval * $signed({1'b0, volume});
        quo    = (prod < 0) ? -((-prod) >>> 7) : (prod >>> 7);
        fin    = sum_reg + 13'sd128;
        found  = 1'b0;
        pick   = '0;
        for (int c = CHANNELS - 1; c >= 0; c--)
        begin
            if (plays_reg[c] == 8'sd0 || snd_reg[c] == cur_reg.sound_id)
            begin
                found = 1'b1;
                pick  = CW'(c);
            end
        end
        act = '0;
        for (int c = 0; c < CHANNELS && c < 4; c++)
        begin
            act[c] = plays_reg[c] != 8'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && q_valid && q_take && q_item.command == mpcm_pkg::CMD_WRITE)
        begin
            smem[AW'(q_item.write_address)] <= q_item.write_data;
        end
        if (st_reg == ST_READ)
        begin
            rdata_reg <= smem[raddr];
        end
        if (st_reg == ST_IDLE)
        begin
            cur_reg <= q_item;
        end
        prod_reg <= quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            ch_reg  <= '0;
            ov_reg  <= 1'b0;
            sum_reg <= '0;
            use_reg <= 1'b0;
            out_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                plays_reg[c] <= '0;
                snd_reg[c]   <= '0;
                start_reg[c] <= '0;
                len_reg[c]   <= '0;
                ptr_reg[c]   <= '0;
                rem_reg[c]   <= '0;
            end
        end
        else
        begin
            // In ST_DONE the valid flag is handled by the state itself.
            if (ov_reg && !out_stall && st_reg != ST_DONE)
            begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_take)
                    begin
                        case (q_item.command)
                            mpcm_pkg::CMD_TICK:
                            begin
                                st_reg  <= ST_READ;
                                ch_reg  <= '0;
                                sum_reg <= '0;
                            end
                            mpcm_pkg::CMD_PLAY:
                            begin
                                st_reg <= ST_PLAY;
                            end
                            mpcm_pkg::CMD_STOP:
                            begin
                                for (int c = 0; c < CHANNELS; c++)
                                begin
                                    if (snd_reg[c] == q_item.sound_id)
                                    begin
                                        plays_reg[c] <= '0;
                                    end
                                end
                            end
                            mpcm_pkg::CMD_STOP_ALL:
                            begin
                                for (int c = 0; c < CHANNELS; c++)
                                begin
                                    plays_reg[c] <= '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_PLAY:
                begin
                    if (found)
                    begin
                        plays_reg[pick] <= cur_reg.loop_count;
                        snd_reg[pick]   <= cur_reg.sound_id;
                        start_reg[pick] <= cur_reg.start_address;
                        len_reg[pick]   <= cur_reg.sound_length;
                        ptr_reg[pick]   <= cur_reg.start_address;
                        rem_reg[pick]   <= cur_reg.sound_length;
                    end
                    st_reg <= ST_IDLE;
                end
                ST_READ:
                begin
                    // Memory read and voice advance happen together.
                    use_reg <= go_c;
                    if (act_c)
                    begin
                        plays_reg[ch_reg] <= wrap_c ? pl_dec : plays_reg[ch_reg];
                    end
                    if (go_c)
                    begin
                        ptr_reg[ch_reg] <= (wrap_c ? start_reg[ch_reg] : ptr_reg[ch_reg]) + 16'd1;
                        rem_reg[ch_reg] <= (wrap_c ? len_reg[ch_reg] : rem_reg[ch_reg]) - 16'd1;
                    end
                    st_reg <= go_c ? ST_MUL : ST_ACC;
                end
                ST_MUL:
                begin
                    st_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (use_reg)
                    begin
                        sum_reg <= sum_reg + 13'(prod_reg);
                    end
                    use_reg <= 1'b0;
                    if ({1'b0, ch_reg} == CH_LAST)
                    begin
                        st_reg <= ST_DONE;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                        st_reg <= ST_READ;
                    end
                end
                ST_DONE:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg <= 1'b1;
                        out_reg.active_channels <= act;
                        if (mute)
                        begin
                            out_reg.mixed_sample <= mpcm_pkg::SAMPLE_MID;
                        end
                        else if (fin > 13'sd255)
                        begin
                            out_reg.mixed_sample <= 8'hff;
                        end
                        else if (fin < 13'sd0)
                        begin
                            out_reg.mixed_sample <= 8'h00;
                        end
                        else
                        begin
                            out_reg.mixed_sample <= fin[7:0];
                        end
                        st_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) (ov_reg && out_stall) |=> ov_reg)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n) (st_reg == ST_MUL) |=> (st_reg == ST_ACC))
        else $error("multiply not followed by accumulate");
    assert property (@(posedge clk) disable iff (!rst_n) q_take |-> (st_reg == ST_IDLE))
        else $error("queue read while busy");

endmodule

/* rtl/core/multichannel_pcm_sample_mixer.sv */
// Multichannel PCM sample mixer.
// Input channel: in_valid / in_stall with in_item (command and its operands).
// Output channel: out_valid / out_stall with out_item; one item per tick.
// Play, stop, stop-all and sample writes give no output item.
// Configuration: cfg_we, cfg_index (0 volume, 1 mute), cfg_data.
// A two-entry queue sits between the input and the mixing engine.
// A tick walks the channels one at a time: a playing channel passes through
// memory read, scale and accumulate states, while an idle one skips the
// scale state; a last state clamps and registers the result. Play passes
// through an extra state that loads the channel; other commands take effect
// as they leave the queue.
// Reset leaves every channel idle, volume at 128 and mute off; sample memory
// has no reset and must be written before voices read it.
// When out_stall holds, the result waits in the output register; the engine
// goes on with later commands until its next result is ready, then waits,
// and the queue fills until in_stall rises.
module multichannel_pcm_sample_mixer
#(
    parameter int CHANNELS     = mpcm_pkg::CHANNELS_DEF,
    parameter int SAMPLE_DEPTH = mpcm_pkg::SAMPLE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mpcm_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output mpcm_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data
);

    logic               q_valid, q_take;
    mpcm_pkg::in_item_t q_item;
    logic [7:0]         volume_reg;
    logic               mute_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= mpcm_pkg::SAMPLE_MID;
            mute_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mpcm_pkg::CFG_VOLUME)
            begin
                volume_reg <= cfg_data;
            end
            else
            begin
                mute_reg <= cfg_data[0];
            end
        end
    end

    mpcm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item)
    );

    mpcm_back #(.CHANNELS(CHANNELS), .SAMPLE_DEPTH(SAMPLE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_item    (q_item),
        .volume    (volume_reg),
        .mute      (mute_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

/* dv/multichannel_pcm_sample_mixer_test.sv */
module multichannel_pcm_sample_mixer_test;

    localparam int NUM_VOICES = 4;
    localparam int DRAIN_CYCLES = 40;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    mpcm_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall;
    mpcm_pkg::out_item_t out_item;
    logic                cfg_we;
    logic                cfg_index;
    logic [7:0]          cfg_data;

    multichannel_pcm_sample_mixer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state.
    logic [7:0]        mem_img [0:65535];
    logic signed [7:0] v_plays [NUM_VOICES];
    logic [7:0]        v_sound [NUM_VOICES];
    logic [15:0]       v_start [NUM_VOICES];
    logic [15:0]       v_len [NUM_VOICES];
    logic [15:0]       v_ptr [NUM_VOICES];
    logic [15:0]       v_rem [NUM_VOICES];
    logic [7:0]        gain;
    logic              muted;

    mpcm_pkg::in_item_t  cmd_queue[$];
    mpcm_pkg::out_item_t mix_expected[$];
    int        mismatches;
    int        send_gap;
    int        recv_gap;
    bit        hold_send;
    bit        in_taken;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int scaled_fetch(int c);
        int v;
        v = int'(mem_img[v_ptr[c]]) - int'(mpcm_pkg::SAMPLE_MID);
        v_ptr[c] = v_ptr[c] + 16'd1;
        v_rem[c] = v_rem[c] - 16'd1;
        return (v * int'(gain)) / 128;
    endfunction

    task automatic predict_mix(input mpcm_pkg::in_item_t it);
        int                  sum;
        mpcm_pkg::out_item_t r;
        sum = 0;
        case (it.command)
            mpcm_pkg::CMD_TICK:
            begin
                for (int c = 0; c < NUM_VOICES; c++)
                begin
                    if (v_plays[c] != 0)
                    begin
                        if (v_rem[c] > 0)
                            sum += scaled_fetch(c);
                        else
                        begin
                            if (v_plays[c] > 0)
                                v_plays[c] = v_plays[c] - 8'sd1;
                            if (v_plays[c] != 0)
                            begin
                                v_ptr[c] = v_start[c];
                                v_rem[c] = v_len[c];
                                sum += scaled_fetch(c);
                            end
                        end
                    end
                end
                for (int c = 0; c < NUM_VOICES; c++)
                    r.active_channels[c] = (v_plays[c] != 0);
                if (muted)
                    r.mixed_sample = mpcm_pkg::SAMPLE_MID;
                else
                begin
                    sum += int'(mpcm_pkg::SAMPLE_MID);
                    if (sum > 255)
                        sum = 255;
                    if (sum < 0)
                        sum = 0;
                    r.mixed_sample = sum[7:0];
                end
                mix_expected.push_back(r);
            end
            mpcm_pkg::CMD_PLAY:
            begin
                if (it.sound_length != 0)
                begin
                    for (int c = 0; c < NUM_VOICES; c++)
                    begin
                        if (v_plays[c] == 0 || v_sound[c] == it.sound_id)
                        begin
                            v_plays[c] = it.loop_count;
                            v_sound[c] = it.sound_id;
                            v_start[c] = it.start_address;
                            v_len[c] = it.sound_length;
                            v_ptr[c] = it.start_address;
                            v_rem[c] = it.sound_length;
                            break;
                        end
                    end
                end
            end
            mpcm_pkg::CMD_STOP:
                for (int c = 0; c < NUM_VOICES; c++)
                    if (v_sound[c] == it.sound_id)
                        v_plays[c] = 0;
            mpcm_pkg::CMD_STOP_ALL:
                for (int c = 0; c < NUM_VOICES; c++)
                    v_plays[c] = 0;
            mpcm_pkg::CMD_WRITE:
                mem_img[it.write_address] = it.write_data;
            default:
                ;
        endcase
    endtask

    // Acceptance is taken at the rising edge, where the handshake is decided.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // Driver: the predictor runs right after acceptance, so state follows the block.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                predict_mix(cmd_queue.pop_front());
                send_gap = $urandom_range(0, 16);
            end
            if (in_taken || !in_valid)
            begin
                if (send_gap > 0 || cmd_queue.size() == 0 || hold_send)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap = send_gap - 1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_item <= cmd_queue[0];
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                out_stall <= 1'b1;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_valid)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
        end
    end

    always @(posedge clk)
    begin
        mpcm_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (mix_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: sample %0d active %b",
                             out_item.mixed_sample, out_item.active_channels);
            end
            else
            begin
                want = mix_expected.pop_front();
                if (out_item.mixed_sample !== want.mixed_sample ||
                    out_item.active_channels !== want.active_channels)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: sample exp %0d got %0d, active exp %b got %b",
                                 want.mixed_sample, out_item.mixed_sample,
                                 want.active_channels, out_item.active_channels);
                end
            end
        end
    end

    function automatic mpcm_pkg::in_item_t blank_item(logic [2:0] cmd);
        mpcm_pkg::in_item_t it;
        it = '0;
        it.command = cmd;
        return it;
    endfunction

    task automatic queue_write(logic [15:0] addr, logic [7:0] data);
        mpcm_pkg::in_item_t it;
        it = blank_item(mpcm_pkg::CMD_WRITE);
        it.write_address = addr;
        it.write_data = data;
        it.sound_id = 8'($urandom);
        cmd_queue.push_back(it);
    endtask

    task automatic queue_play(logic [7:0] id, logic [15:0] start, logic [15:0] len,
                              logic [7:0] loops);
        mpcm_pkg::in_item_t it;
        it = blank_item(mpcm_pkg::CMD_PLAY);
        it.sound_id = id;
        it.start_address = start;
        it.sound_length = len;
        it.loop_count = loops;
        it.write_address = 16'($urandom);
        it.write_data = 8'($urandom);
        cmd_queue.push_back(it);
    endtask

    task automatic queue_cmd(logic [2:0] cmd, logic [7:0] id);
        mpcm_pkg::in_item_t it;
        it = blank_item(cmd);
        it.sound_id = id;
        cmd_queue.push_back(it);
    endtask

    // Waits until every queued item has been taken and every result seen.
    task automatic settle;
        while (cmd_queue.size() > 0 || in_valid || mix_expected.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == mpcm_pkg::CFG_VOLUME)
            gain = val;
        else
            muted = val[0];
    endtask

    // Sounds live in a few regions whose every byte is written up front,
    // so a voice can only read written memory.
    logic [15:0] region_base [4] = '{16'h0000, 16'h4000, 16'hfff0, 16'h8000};
    localparam int REGION_LEN = 16;

    task automatic random_play;
        int r;
        int off;
        int len;
        logic [7:0] loops;
        r = $urandom_range(0, 3);
        off = $urandom_range(0, REGION_LEN - 1);
        len = $urandom_range(0, REGION_LEN - off);
        if (region_base[r] == 16'hfff0 && $urandom_range(0, 1))
        begin
            // Pointer wraps from 0xffff to 0x0000.
            off = $urandom_range(8, 15);
            len = $urandom_range(1, REGION_LEN - off + REGION_LEN);
        end
        case ($urandom_range(0, 5))
            0: loops = 8'hff;
            1: loops = 8'h80 | 8'($urandom);
            2: loops = 8'd0;
            3: loops = 8'd127;
            default: loops = 8'($urandom_range(1, 4));
        endcase
        queue_play($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 5)),
                   region_base[r] + 16'(off), 16'(len), loops);
    endtask

    initial
    begin
        int ticks;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mpcm_pkg::CFG_VOLUME;
        cfg_data = 8'd0;
        mismatches = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_send = 1'b0;
        gain = 8'd128;
        muted = 1'b0;
        for (int c = 0; c < NUM_VOICES; c++)
        begin
            v_plays[c] = 0;
            v_sound[c] = 0;
            v_start[c] = 0;
            v_len[c] = 0;
            v_ptr[c] = 0;
            v_rem[c] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes of sample bytes, every command.
        for (int r = 0; r < 4; r++)
            for (int i = 0; i < REGION_LEN; i++)
                queue_write(region_base[r] + 16'(i),
                            (i == 0) ? 8'h00 : (i == 1) ? 8'hff : (i == 2) ? 8'h80 : 8'($urandom));
        queue_write(16'hffff, 8'hff);
        queue_cmd(mpcm_pkg::CMD_TICK, 8'd0);
        queue_play(8'd1, 16'h0000, 16'd3, 8'd2);
        queue_play(8'd2, 16'h4001, 16'd1, 8'hff);
        queue_play(8'd3, 16'h4001, 16'd2, 8'h80);
        queue_play(8'd4, 16'h4001, 16'd1, 8'd127);
        queue_play(8'd5, 16'h4001, 16'd1, 8'd1);
        queue_play(8'd6, 16'h4000, 16'd0, 8'd1);
        for (int i = 0; i < 8; i++)
            queue_cmd(mpcm_pkg::CMD_TICK, 8'd0);
        queue_play(8'd1, 16'hfffe, 16'd4, 8'd0);
        queue_cmd(mpcm_pkg::CMD_TICK, 8'd0);
        queue_cmd(mpcm_pkg::CMD_STOP, 8'd2);
        queue_cmd(mpcm_pkg::CMD_TICK, 8'd0);
        queue_cmd(3'd5, 8'd0);
        queue_cmd(3'd7, 8'd0);
        queue_cmd(mpcm_pkg::CMD_STOP_ALL, 8'd0);
        queue_cmd(mpcm_pkg::CMD_TICK, 8'd0);
        settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_reg(mpcm_pkg::CFG_VOLUME, 8'd0);
                1: write_reg(mpcm_pkg::CFG_VOLUME, 8'd255);
                2: write_reg(mpcm_pkg::CFG_MUTE, 8'd1);
                3: write_reg(mpcm_pkg::CFG_MUTE, 8'd0);
                4: write_reg(mpcm_pkg::CFG_VOLUME, 8'($urandom_range(1, 127)));
                default: write_reg(mpcm_pkg::CFG_VOLUME, 8'd128);
            endcase
            for (int n = 0; n < 230; n++)
            begin
                ticks = $urandom_range(0, 99);
                if (ticks < 55)
                    queue_cmd(mpcm_pkg::CMD_TICK, 8'($urandom));
                else if (ticks < 80)
                    random_play();
                else if (ticks < 88)
                    queue_cmd(mpcm_pkg::CMD_STOP, 8'($urandom_range(0, 6)));
                else if (ticks < 91)
                    queue_cmd(mpcm_pkg::CMD_STOP_ALL, 8'($urandom));
                else if (ticks < 97)
                    queue_write(region_base[$urandom_range(0, 3)] +
                                16'($urandom_range(0, REGION_LEN - 1)), 8'($urandom));
                else
                    queue_cmd(3'($urandom_range(5, 7)), 8'($urandom));
                if (n == 100)
                begin
                    hold_send = 1'b1;
                    while (in_valid || mix_expected.size() > 0)
                        @(negedge clk);
                    hold_send = 1'b0;
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mpcm_pkg.sv
rtl/core/mpcm_front.sv
rtl/core/mpcm_back.sv
rtl/core/multichannel_pcm_sample_mixer.sv
dv/multichannel_pcm_sample_mixer_test.sv
